FILE: rtl/nbd_pkg.sv
package nbd_pkg;

   // Calendar constants
   localparam logic [4:0]  MONTH_LONG  = 5'd31;
   localparam logic [4:0]  MONTH_SHORT = 5'd30;
   localparam logic [4:0]  FEB_DAYS    = 5'd28;
   localparam logic [3:0]  MONTH_JAN   = 4'd1;
   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_MAR   = 4'd3;
   localparam logic [3:0]  MONTH_APR   = 4'd4;
   localparam logic [3:0]  MONTH_JUN   = 4'd6;
   localparam logic [3:0]  MONTH_SEP   = 4'd9;
   localparam logic [3:0]  MONTH_NOV   = 4'd11;
   localparam logic [3:0]  MONTH_DEC   = 4'd12;
   localparam logic [14:0] MAX_YEAR    = 15'd9999;

   // Weekday codes, 1 Monday .. 7 Sunday
   localparam logic [2:0]  WD_MON = 3'd1;
   localparam logic [2:0]  WD_FRI = 3'd5;
   localparam logic [2:0]  WD_SAT = 3'd6;
   localparam logic [2:0]  WD_SUN = 3'd7;

   // Days advanced
   localparam logic [1:0]  ADV_ONE   = 2'd1;
   localparam logic [1:0]  ADV_TWO   = 2'd2;
   localparam logic [1:0]  ADV_THREE = 2'd3;

   typedef struct packed {
      logic [13:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
   } req_type;

   typedef struct packed {
      logic [13:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [2:0]  weekday_out;
      logic [1:0]  days_advanced;
      logic        year_overflow;
   } rsp_type;

   // Year split into centuries and remainder, month clamped to 1..12
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [7:0]  cent;
      logic [6:0]  rem;
   } split_type;

   // Date after the first day step, plus the year terms of the weekday sum
   typedef struct packed {
      logic [14:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        leap;
      logic [3:0]  zmonth;
      logic [7:0]  zcent;
      logic [6:0]  zrem;
   } step_type;

   typedef struct packed {
      logic [14:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        leap;
      logic [2:0]  weekday;
   } wkd_type;

   // Days in a month; month is already clamped to 1..12
   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] month);
      logic [4:0] len;
      if (month == MONTH_FEB) begin
         len = leap ? (FEB_DAYS + 5'd1) : FEB_DAYS;
      end else if (month == MONTH_APR || month == MONTH_JUN ||
                   month == MONTH_SEP || month == MONTH_NOV) begin
         len = MONTH_SHORT;
      end else begin
         len = MONTH_LONG;
      end
      return len;
   endfunction

endpackage

FILE: rtl/nbd_year_split.sv
module nbd_year_split import nbd_pkg::*; (
   input  req_type   req,
   output split_type split
);

   // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [13:0] CENTURY     = 14'd100;

   logic [26:0] prod;
   logic [7:0]  cent;
   logic [13:0] hundreds;
   logic [13:0] rem_full;

   // Century and year-in-century
   always_comb begin
      prod     = 27'(req.year_in) * 27'(RECIP_100);
      cent     = prod[RECIP_SHIFT +: 8];
      hundreds = 14'(cent) * CENTURY;
      rem_full = req.year_in - hundreds;
   end

   // Month zero counts as January, anything past twelve as December
   always_comb begin
      split.year = req.year_in;
      split.day  = req.day_in;
      split.cent = cent;
      split.rem  = rem_full[6:0];
      if (req.month_in == 4'd0) begin
         split.month = MONTH_JAN;
      end else if (req.month_in > MONTH_DEC) begin
         split.month = MONTH_DEC;
      end else begin
         split.month = req.month_in;
      end
   end

endmodule

FILE: rtl/nbd_day_step.sv
module nbd_day_step import nbd_pkg::*; (
   input  split_type split,
   output step_type  step
);

   logic       leap;
   logic [4:0] len;
   logic       roll_year;
   logic       borrow;
   logic [3:0] month1;

   // Leap year: divisible by 4, and not a whole century unless centuries divide by 4
   always_comb begin
      leap = (split.year[1:0] == 2'd0) && ((split.rem != 7'd0) || (split.cent[1:0] == 2'd0));
      len  = month_len(leap, split.month);
   end

   // One calendar day forward
   always_comb begin
      roll_year  = 1'b0;
      month1     = split.month;
      step.day   = split.day + 5'd1;
      if (split.day >= len) begin
         step.day = 5'd1;
         if (split.month >= MONTH_DEC) begin
            month1    = MONTH_JAN;
            roll_year = 1'b1;
         end else begin
            month1 = split.month + 4'd1;
         end
      end
      step.month = month1;
      step.year  = {1'b0, split.year} + 15'(roll_year);
      // after a year roll the date is in January, so the old leap flag is never consulted
      step.leap  = leap;
   end

   // Zeller terms: January and February count as months 13 and 14 of the year before;
   // the year is offset by 400 so the sum stays positive
   always_comb begin
      borrow      = (month1 < MONTH_MAR);
      step.zmonth = borrow ? (month1 + 4'd12) : month1;
      step.zcent  = split.cent + 8'd4;
      step.zrem   = split.rem;
      if (roll_year && !borrow) begin
         if (split.rem == 7'd99) begin
            step.zrem  = 7'd0;
            step.zcent = split.cent + 8'd5;
         end else begin
            step.zrem = split.rem + 7'd1;
         end
      end else if (borrow && !roll_year) begin
         if (split.rem == 7'd0) begin
            step.zrem  = 7'd99;
            step.zcent = split.cent + 8'd3;
         end else begin
            step.zrem = split.rem - 7'd1;
         end
      end
   end

endmodule

FILE: rtl/nbd_weekday.sv
module nbd_weekday import nbd_pkg::*; (
   input  step_type step,
   output wkd_type  wkd
);

   // floor(x / 7) = (x * 2341) >> 14, exact for x below 2048
   localparam logic [11:0] RECIP_7   = 12'd2341;
   localparam int          R7_SHIFT  = 14;

   // floor(13 * (m + 1) / 5) for Zeller months 3..14
   function automatic logic [5:0] month_term(input logic [3:0] zm);
      logic [5:0] t;
      unique case (zm)
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         4'd13:   t = 6'd36;
         4'd14:   t = 6'd39;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   logic [10:0] sum;
   logic [22:0] prod;
   logic [10:0] quot;
   logic [10:0] h_full;
   logic [2:0]  h;

   // Zeller sum, then reduce mod 7
   always_comb begin
      sum = 11'(step.day) + 11'(month_term(step.zmonth)) + 11'(step.zrem)
          + 11'(step.zrem[6:2]) + 11'(step.zcent[7:2]) + 11'(step.zcent) * 11'd5;
      prod   = 23'(sum) * 23'(RECIP_7);
      quot   = 11'(prod[22:R7_SHIFT]);
      h_full = sum - quot * 11'd7;
      h      = h_full[2:0];
   end

   // h: 0 Saturday, 1 Sunday, 2 Monday ...
   always_comb begin
      wkd.year    = step.year;
      wkd.month   = step.month;
      wkd.day     = step.day;
      wkd.leap    = step.leap;
      wkd.weekday = (h >= 3'd2) ? (h - 3'd1) : (h + 3'd6);
   end

endmodule

FILE: rtl/nbd_finish.sv
module nbd_finish import nbd_pkg::*; (
   input  wkd_type wkd,
   output rsp_type rsp
);

   logic [1:0]  extra;
   logic [1:0]  adv;
   logic [4:0]  len;
   logic [5:0]  day_sum;
   logic [14:0] year2;
   logic [3:0]  month2;
   logic [4:0]  day2;
   logic [2:0]  wd2;

   // Weekend skip: Saturday goes two more days, Sunday one
   always_comb begin
      priority if (wkd.weekday == WD_SAT) begin
         extra = 2'd2;
         adv   = ADV_THREE;
      end else if (wkd.weekday == WD_SUN) begin
         extra = 2'd1;
         adv   = ADV_TWO;
      end else begin
         extra = 2'd0;
         adv   = ADV_ONE;
      end
   end

   // The date is valid here, so at most one month boundary is crossed
   always_comb begin
      len     = month_len(wkd.leap, wkd.month);
      day_sum = 6'(wkd.day) + 6'(extra);
      year2   = wkd.year;
      month2  = wkd.month;
      day2    = day_sum[4:0];
      wd2     = (extra != 2'd0) ? WD_MON : wkd.weekday;
      if (day_sum > 6'(len)) begin
         day2 = 5'(day_sum - 6'(len));
         if (wkd.month == MONTH_DEC) begin
            month2 = MONTH_JAN;
            year2  = wkd.year + 15'd1;
         end else begin
            month2 = wkd.month + 4'd1;
         end
      end
   end

   // Past the last representable year: hold at 9999-12-31, a Friday
   always_comb begin
      rsp.days_advanced = adv;
      if (year2 > MAX_YEAR) begin
         rsp.year_overflow = 1'b1;
         rsp.year_out      = MAX_YEAR[13:0];
         rsp.month_out     = MONTH_DEC;
         rsp.day_out       = MONTH_LONG;
         rsp.weekday_out   = WD_FRI;
      end else begin
         rsp.year_overflow = 1'b0;
         rsp.year_out      = year2[13:0];
         rsp.month_out     = month2;
         rsp.day_out       = day2;
         rsp.weekday_out   = wd2;
      end
   end

endmodule

FILE: rtl/next_business_day_date.sv
// Next business day of a Gregorian date.
//
// Request channel (req_valid / req_ready / req_data): year, month and day.
// Response channel (rsp_valid / rsp_ready / rsp_data): the next weekday date,
// its weekday (1 Monday .. 5 Friday), the calendar days advanced (1 to 3) and
// an overflow flag that holds the date at 9999-12-31 when year 9999 is passed.
// Every request gives exactly one response, in order.
//
// Throughput: one request per cycle while the receiver takes each response,
// set by a five-register pipeline (input, year split, day step, weekday,
// response). Each stage loads whenever it is empty or its successor loads,
// so a stalled receiver only holds back the stages behind the full ones;
// bubbles close up and requests keep being taken until every stage holds a
// request.
//
// Reset clears the stage valid flags only; the pipeline is then empty and
// req_ready is high.
module next_business_day_date import nbd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type   req_ff;
   split_type split_ff, split_in;
   step_type  step_ff, step_in;
   wkd_type   wkd_ff, wkd_in;
   rsp_type   rsp_ff, rsp_in;

   logic req_vld_ff, split_vld_ff, step_vld_ff, wkd_vld_ff, rsp_vld_ff;
   logic req_load, split_load, step_load, wkd_load, rsp_load;

   // Per-stage load enables, from the output backwards
   always_comb begin
      rsp_load   = !rsp_vld_ff   || rsp_ready;
      wkd_load   = !wkd_vld_ff   || rsp_load;
      step_load  = !step_vld_ff  || wkd_load;
      split_load = !split_vld_ff || step_load;
      req_load   = !req_vld_ff   || split_load;
   end

   assign req_ready = req_load;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   nbd_year_split u_split (
      .req   (req_ff),
      .split (split_in)
   );

   nbd_day_step u_step (
      .split (split_ff),
      .step  (step_in)
   );

   nbd_weekday u_wkd (
      .step (step_ff),
      .wkd  (wkd_in)
   );

   nbd_finish u_finish (
      .wkd (wkd_ff),
      .rsp (rsp_in)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff   <= 1'b0;
         split_vld_ff <= 1'b0;
         step_vld_ff  <= 1'b0;
         wkd_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         if (req_load) begin
            req_vld_ff <= req_valid;
         end
         if (split_load) begin
            split_vld_ff <= req_vld_ff;
         end
         if (step_load) begin
            step_vld_ff <= split_vld_ff;
         end
         if (wkd_load) begin
            wkd_vld_ff <= step_vld_ff;
         end
         if (rsp_load) begin
            rsp_vld_ff <= wkd_vld_ff;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (req_load) begin
         req_ff <= req_data;
      end
      if (split_load) begin
         split_ff <= split_in;
      end
      if (step_load) begin
         step_ff <= step_in;
      end
      if (wkd_load) begin
         wkd_ff <= wkd_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
